// File: hw/rtl/apsm_pkg.sv
// Shared types and constants for the appliance power subset matcher.
package apsm_pkg;

    localparam int PW  = 20;
    localparam int TW  = 16;
    localparam int SLW = 3;
    localparam int OMW = 7;
    localparam int CIW = 2;

    localparam logic [CIW-1:0] CFG_SPLIT     = 2'd0;
    localparam logic [CIW-1:0] CFG_TOL_BELOW = 2'd1;
    localparam logic [CIW-1:0] CFG_TOL_ABOVE = 2'd2;

    localparam logic OP_LEARN    = 1'b0;
    localparam logic OP_IDENTIFY = 1'b1;

    localparam logic [PW-1:0] SPLIT_RST     = 20'd6000;
    localparam logic [TW-1:0] TOL_BELOW_RST = 16'd80;
    localparam logic [TW-1:0] TOL_ABOVE_RST = 16'd150;

    typedef struct packed {
        logic           op;
        logic [SLW-1:0] slot;
        logic [PW-1:0]  measured_power;
    } in_t;

    typedef struct packed {
        logic [OMW-1:0] on_mask;
        logic           matched;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_WALK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic learn;
        logic start;
        logic pre_step;
        logic walk_step;
    } cmd_t;

    typedef struct packed {
        logic pre_last;
        logic walk_last;
        logic hit;
    } status_t;

endpackage

// File: hw/rtl/apsm_dp.sv
// Datapath: power table, step table, shared accumulator and tolerance compare.
module apsm_dp #(
    parameter int NUM_APPLIANCES = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apsm_pkg::cmd_t                cmd,
    input  apsm_pkg::in_t                 item,
    input  logic                          cfg_we,
    input  logic [apsm_pkg::CIW-1:0]      cfg_index,
    input  logic [apsm_pkg::PW-1:0]       cfg_data,
    output apsm_pkg::status_t             status,
    output apsm_pkg::out_t                result
);

    localparam int N  = NUM_APPLIANCES;
    localparam int SW = apsm_pkg::PW + $clog2(N);
    localparam int KW = (N > 1) ? $clog2(N) : 1;
    localparam int EW = (N > apsm_pkg::OMW) ? N : apsm_pkg::OMW;

    logic [apsm_pkg::PW-1:0] power_reg [N];
    logic [SW-1:0]           delta_reg [N];
    logic [SW-1:0]           prefix_reg;
    logic [SW-1:0]           sum_reg;
    logic [apsm_pkg::PW-1:0] meas_reg;
    logic [KW-1:0]           idx_reg;
    logic [N-1:0]            mask_reg;
    logic [apsm_pkg::PW-1:0] split_reg;
    logic [apsm_pkg::TW-1:0] tol_below_reg;
    logic [apsm_pkg::TW-1:0] tol_above_reg;

    logic                    slot_ok;
    logic [KW-1:0]           learn_idx;
    logic [SW-1:0]           p_ext;
    logic [KW-1:0]           run_len;
    logic [SW-1:0]           meas_ext;
    logic [SW-1:0]           diff;
    logic [apsm_pkg::TW-1:0] tol;
    logic                    hit;
    logic [EW-1:0]           mask_ext;

    // Number of trailing ones of the mask: the slots that the increment turns off.
    function automatic logic [KW-1:0] ones_run(input logic [N-1:0] m);
        logic [KW-1:0] k;
        logic          run;
        k   = '0;
        run = 1'b1;
        for (int i = 0; i < N; i++)
        begin
            if (run && m[i])
            begin
                k = k + 1'b1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return k;
    endfunction

    assign slot_ok   = (item.slot != '0) && (int'(item.slot) <= N);
    assign learn_idx = KW'(item.slot - apsm_pkg::SLW'(1));
    assign p_ext     = SW'(power_reg[idx_reg]);
    assign run_len   = ones_run(mask_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                power_reg[i] <= '0;
            end
            idx_reg       <= '0;
            mask_reg      <= '0;
            split_reg     <= apsm_pkg::SPLIT_RST;
            tol_below_reg <= apsm_pkg::TOL_BELOW_RST;
            tol_above_reg <= apsm_pkg::TOL_ABOVE_RST;
        end
        else
        begin
            if (cmd.learn && slot_ok)
            begin
                power_reg[learn_idx] <= item.measured_power;
            end
            if (cmd.start)
            begin
                idx_reg  <= '0;
                mask_reg <= '0;
            end
            if (cmd.pre_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.walk_step)
            begin
                mask_reg <= mask_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    apsm_pkg::CFG_SPLIT:     split_reg     <= cfg_data;
                    apsm_pkg::CFG_TOL_BELOW: tol_below_reg <= cfg_data[apsm_pkg::TW-1:0];
                    apsm_pkg::CFG_TOL_ABOVE: tol_above_reg <= cfg_data[apsm_pkg::TW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // The step table holds, for each run of trailing ones, what the mask increment
    // adds to the sum: the power of the slot turned on less the prefix turned off.
    // Sums are kept modulo 2^SW; every true sum fits, so the wrap is harmless.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            meas_reg   <= item.measured_power;
            prefix_reg <= '0;
            sum_reg    <= '0;
        end
        if (cmd.pre_step)
        begin
            delta_reg[idx_reg] <= p_ext - prefix_reg;
            prefix_reg         <= prefix_reg + p_ext;
        end
        if (cmd.walk_step)
        begin
            sum_reg <= sum_reg + delta_reg[run_len];
        end
    end

    assign meas_ext = SW'(meas_reg);
    assign diff     = (sum_reg >= meas_ext) ? (sum_reg - meas_ext) : (meas_ext - sum_reg);
    assign tol      = (sum_reg < SW'(split_reg)) ? tol_below_reg : tol_above_reg;
    assign hit      = diff < SW'(tol);
    assign mask_ext = EW'(mask_reg);

    assign status.pre_last  = (idx_reg == KW'(N - 1));
    assign status.walk_last = (mask_reg == '1);
    assign status.hit       = hit;

    assign result.on_mask = hit ? mask_ext[apsm_pkg::OMW-1:0] : '0;
    assign result.matched = hit;

`ifndef SYNTHESIS
    a_no_mask_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (mask_reg != '1))
        else $error("mask counter stepped past the last mask");
`endif

endmodule

// File: hw/rtl/apsm_ctrl.sv
// Sequencer for the matcher, with the request handshake and output register.
module apsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               item_op,
    input  apsm_pkg::status_t  status,
    input  apsm_pkg::out_t     result,
    output apsm_pkg::cmd_t     cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output apsm_pkg::out_t     out_item
);

    apsm_pkg::state_t state_reg;
    apsm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    apsm_pkg::out_t   out_item_reg;
    logic             out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apsm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= result;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            apsm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (item_op == apsm_pkg::OP_IDENTIFY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = apsm_pkg::ST_PRE;
                    end
                    else
                    begin
                        cmd.learn = 1'b1;
                    end
                end
            end
            apsm_pkg::ST_PRE:
            begin
                cmd.pre_step = 1'b1;
                if (status.pre_last)
                begin
                    state_next = apsm_pkg::ST_WALK;
                end
            end
            apsm_pkg::ST_WALK:
            begin
                if (status.hit || status.walk_last)
                begin
                    state_next = apsm_pkg::ST_FIN;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            apsm_pkg::ST_FIN:
            begin
                // The mask and sum are frozen here; a config write can still change the hit while the result waits.
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = apsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_hit_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apsm_pkg::ST_WALK && status.hit) |=> (state_reg == apsm_pkg::ST_FIN))
        else $error("walk continued past a matching mask");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apsm_pkg::ST_FIN && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && state_reg == apsm_pkg::ST_IDLE))
        else $error("finished search did not reach the output register");

    a_identify_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && item_op == apsm_pkg::OP_IDENTIFY)
        |=> (state_reg == apsm_pkg::ST_PRE))
        else $error("identify request did not start the table pass");
`endif

endmodule

// File: hw/rtl/appliance_power_subset_match_unit.sv
// Top level of the appliance power subset matcher.
//
// Requests arrive on in_valid/in_ready with in_item. A learn request stores
// measured_power in the given slot (1..NUM_APPLIANCES) in the cycle it is
// accepted and gives no result. An identify request first runs one pass over
// the power table to build a table of mask-step increments, then tests one
// on/off mask per cycle in ascending order with a single accumulator. The
// first mask within tolerance wins. in_ready is low while a search runs.
// Results leave through a register on out_valid/out_ready; a new request is
// accepted while a result still waits, and a search that finishes against a
// stalled output holds until the register is free.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken.
// Reset clears the power table and loads the default split and tolerances;
// no clearing pass is needed.
module appliance_power_subset_match_unit #(
    parameter int NUM_APPLIANCES = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  apsm_pkg::in_t             in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output apsm_pkg::out_t            out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [apsm_pkg::CIW-1:0]  cfg_index,
    input  logic [apsm_pkg::PW-1:0]   cfg_data
);

    apsm_pkg::cmd_t    cmd;
    apsm_pkg::status_t status;
    apsm_pkg::out_t    result;
    logic              cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    apsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item_op   (in_item.op),
        .status    (status),
        .result    (result),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    apsm_dp #(
        .NUM_APPLIANCES (NUM_APPLIANCES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

endmodule
